>>> sv/iafyp_pkg.sv
// Shared constants and types of the IMU angle frame yaw parser.
`default_nettype none

package iafyp_pkg;

	// Frame layout
	localparam int unsigned FRAME_BYTES = 11;
	localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
	localparam logic [7:0]  HDR_BYTE    = 8'h55;
	localparam logic [7:0]  ANGLE_BYTE  = 8'h53;
	localparam int unsigned YAW_LO_POS  = 6;
	localparam int unsigned YAW_HI_POS  = 7;

	// Scale: raw * 18000 / 2^15, rounded toward zero
	localparam int unsigned SCALE_NUM   = 18000;
	localparam int unsigned SCALE_SHIFT = 15;
	localparam int unsigned PROD_W      = 32;

	// Token queue between framer and scaler
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One token per received byte
	typedef struct packed {
		logic       done;
		logic [7:0] yaw_lo;
		logic [7:0] yaw_hi;
	} tok_t;

endpackage

`default_nettype wire

>>> sv/iafyp_in_if.sv
// Byte input channel of the IMU angle frame yaw parser.
`default_nettype none

interface iafyp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> sv/iafyp_out_if.sv
// Result channel of the IMU angle frame yaw parser.
`default_nettype none

interface iafyp_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] yaw_centideg;
	logic               yaw_valid;
	logic               frame_accepted;

	modport source (output valid, output yaw_centideg, output yaw_valid,
		output frame_accepted, input ready);
	modport sink (input valid, input yaw_centideg, input yaw_valid,
		input frame_accepted, output ready);
endinterface

`default_nettype wire

>>> sv/imu_angle_frame_yaw_parser.sv
// Top level of the IMU angle frame yaw parser: framer, token queue and scaler.
//
// Usage:
//  - rx carries one received serial byte per beat (rx_byte). yaw carries one
//    result beat for every byte beat: the last accepted yaw in centidegrees,
//    the sticky yaw_valid flag and frame_accepted, high on the beat of the
//    byte that closed a frame with a good checksum.
//  - A frame is 0x55, 0x53, payload, checksum; the yaw is the signed
//    little-endian word at bytes 6 and 7, scaled by 18000/32768.
//  - Throughput: one byte per cycle while the queue has room, set by the
//    framer's state update. A byte's result goes through the token queue and
//    then the result register before it shows as a result beat.
//  - When the receiver holds yaw.ready low, the result register holds its
//    beat and the queue fills; rx.ready drops once the queue holds four
//    tokens, and the framer then holds its state.
//  - Reset clears framing, checksum, the stored yaw (reads as zero), the
//    valid flag, the queue and the result register's valid bit. No clearing pass.
`default_nettype none

module imu_angle_frame_yaw_parser (
	input  wire logic    clk,
	input  wire logic    arst_n,
	iafyp_in_if.sink     rx,
	iafyp_out_if.source  yaw
);

	iafyp_pkg::tok_t                   push_tok;
	iafyp_pkg::tok_t                   pop_tok;
	logic                              push;
	logic                              pop;
	logic                              full;
	logic                              empty;
	logic [iafyp_pkg::QCNT_W-1:0]      q_count;

	// Front: frame tracking and checksum, one token per byte
	iafyp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.tok_full (full),
		.tok_push (push),
		.tok_data (push_tok)
	);

	// Decouple framer from result stalls
	iafyp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_tok),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_tok),
		.empty     (empty),
		.count     (q_count)
	);

	// Back: scale accepted yaw, hold it, drive the result beat
	iafyp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_empty (empty),
		.tok_data  (pop_tok),
		.tok_pop   (pop),
		.yaw       (yaw)
	);

	// A completed frame always reports the valid flag
	assert property (@(posedge clk) disable iff (!arst_n)
		yaw.valid && yaw.frame_accepted |-> yaw.yaw_valid)
		else $error("frame_accepted without yaw_valid");

	// Scaled yaw stays inside half a turn
	assert property (@(posedge clk) disable iff (!arst_n)
		yaw.valid |-> (yaw.yaw_centideg >= -16'sd18000 && yaw.yaw_centideg <= 16'sd17999))
		else $error("yaw out of range");

	// A byte is only taken when the queue has room
	assert property (@(posedge clk) disable iff (!arst_n)
		rx.valid && rx.ready |-> q_count < iafyp_pkg::QCNT_W'(iafyp_pkg::QUEUE_DEPTH))
		else $error("byte accepted into full queue");

	// Every popped token becomes a result beat on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> yaw.valid)
		else $error("popped token produced no result beat");

endmodule

`default_nettype wire

>>> sv/iafyp_front.sv
// Framer: tracks header, position and checksum, emits one token per byte.
`default_nettype none

module iafyp_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	iafyp_in_if.sink            rx,
	input  wire logic           tok_full,
	output logic                tok_push,
	output iafyp_pkg::tok_t     tok_data
);

	localparam logic [iafyp_pkg::POS_W-1:0] LAST_POS =
		iafyp_pkg::POS_W'(iafyp_pkg::FRAME_BYTES - 1);
	localparam logic [iafyp_pkg::POS_W-1:0] LO_POS =
		iafyp_pkg::POS_W'(iafyp_pkg::YAW_LO_POS);
	localparam logic [iafyp_pkg::POS_W-1:0] HI_POS =
		iafyp_pkg::POS_W'(iafyp_pkg::YAW_HI_POS);
	localparam logic [iafyp_pkg::POS_W-1:0] POS_HUNT = '0;
	localparam logic [iafyp_pkg::POS_W-1:0] POS_TYPE = iafyp_pkg::POS_W'(1);

	logic [iafyp_pkg::POS_W-1:0] pos_q;
	logic [7:0]                  sum_q;
	logic [7:0]                  lo_q;
	logic [7:0]                  hi_q;
	logic                        accept;
	logic                        at_end;

	assign rx.ready = ~tok_full;
	assign accept   = rx.valid & rx.ready;
	assign at_end   = (pos_q >= LAST_POS);
	assign tok_push = accept;

	always_comb begin
		tok_data.done   = at_end && (sum_q == rx.rx_byte);
		tok_data.yaw_lo = lo_q;
		tok_data.yaw_hi = hi_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
			sum_q <= '0;
		end else if (accept) begin
			if (pos_q == POS_HUNT) begin
				if (rx.rx_byte == iafyp_pkg::HDR_BYTE) begin
					sum_q <= rx.rx_byte;
					pos_q <= POS_TYPE;
				end
			end else if (pos_q == POS_TYPE && rx.rx_byte != iafyp_pkg::ANGLE_BYTE) begin
				// repeated header restarts the frame, anything else drops it
				if (rx.rx_byte == iafyp_pkg::HDR_BYTE) begin
					sum_q <= rx.rx_byte;
					pos_q <= POS_TYPE;
				end else begin
					pos_q <= POS_HUNT;
				end
			end else if (at_end) begin
				pos_q <= POS_HUNT;
			end else begin
				sum_q <= sum_q + rx.rx_byte;
				pos_q <= pos_q + POS_TYPE;
			end
		end
	end

	// yaw bytes are always written inside a frame before they are used
	always_ff @(posedge clk) begin
		if (accept && !at_end && pos_q != POS_HUNT && pos_q != POS_TYPE) begin
			if (pos_q == LO_POS) begin
				lo_q <= rx.rx_byte;
			end
			if (pos_q == HI_POS) begin
				hi_q <= rx.rx_byte;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/iafyp_queue.sv
// Short token queue between framer and scaler.
`default_nettype none

module iafyp_queue (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire iafyp_pkg::tok_t               push_data,
	output logic                               full,
	input  wire logic                          pop,
	output iafyp_pkg::tok_t                    pop_data,
	output logic                               empty,
	output logic [iafyp_pkg::QCNT_W-1:0]       count
);

	localparam logic [iafyp_pkg::QCNT_W-1:0] DEPTH_C =
		iafyp_pkg::QCNT_W'(iafyp_pkg::QUEUE_DEPTH);
	localparam logic [iafyp_pkg::QPTR_W-1:0] LAST_SLOT =
		iafyp_pkg::QPTR_W'(iafyp_pkg::QUEUE_DEPTH - 1);

	iafyp_pkg::tok_t                 slot_q [iafyp_pkg::QUEUE_DEPTH];
	logic [iafyp_pkg::QPTR_W-1:0]    wr_q;
	logic [iafyp_pkg::QPTR_W-1:0]    rd_q;
	logic [iafyp_pkg::QCNT_W-1:0]    cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign full     = (cnt_q == DEPTH_C);
	assign empty    = (cnt_q == '0);
	assign count    = cnt_q;
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_SLOT) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_SLOT) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

>>> sv/iafyp_back.sv
// Scaler: converts accepted frames to centidegrees and drives the result register.
`default_nettype none

module iafyp_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           tok_empty,
	input  wire iafyp_pkg::tok_t tok_data,
	output logic                tok_pop,
	iafyp_out_if.source         yaw
);

	localparam logic signed [iafyp_pkg::PROD_W-1:0] SCALE_C =
		iafyp_pkg::PROD_W'(iafyp_pkg::SCALE_NUM);
	localparam logic signed [iafyp_pkg::PROD_W-1:0] ROUND_C =
		iafyp_pkg::PROD_W'((1 << iafyp_pkg::SCALE_SHIFT) - 1);

	logic signed [15:0]                   yaw_value_q;
	logic                                 valid_q;
	logic                                 out_v_q;
	logic signed [15:0]                   out_yaw_q;
	logic                                 out_yv_q;
	logic                                 out_fa_q;
	logic signed [iafyp_pkg::PROD_W-1:0]  raw;
	logic signed [iafyp_pkg::PROD_W-1:0]  prod;
	logic signed [iafyp_pkg::PROD_W-1:0]  biased;
	logic signed [iafyp_pkg::PROD_W-1:0]  shifted;
	logic signed [15:0]                   scaled;

	// raw * 18000 / 32768, truncated toward zero: bias negatives before the shift
	always_comb begin
		raw     = iafyp_pkg::PROD_W'(signed'({tok_data.yaw_hi, tok_data.yaw_lo}));
		prod    = raw * SCALE_C;
		biased  = prod[iafyp_pkg::PROD_W-1] ? prod + ROUND_C : prod;
		shifted = biased >>> iafyp_pkg::SCALE_SHIFT;
		scaled  = shifted[15:0];
	end

	assign tok_pop = ~tok_empty & (~out_v_q | yaw.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_value_q <= '0;
			valid_q     <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (tok_pop) begin
				out_v_q <= 1'b1;
				if (tok_data.done) begin
					yaw_value_q <= scaled;
					valid_q     <= 1'b1;
				end
			end else if (yaw.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_pop) begin
			out_yaw_q <= tok_data.done ? scaled : yaw_value_q;
			out_yv_q  <= tok_data.done | valid_q;
			out_fa_q  <= tok_data.done;
		end
	end

	assign yaw.valid          = out_v_q;
	assign yaw.yaw_centideg   = out_yaw_q;
	assign yaw.yaw_valid      = out_yv_q;
	assign yaw.frame_accepted = out_fa_q;

endmodule

`default_nettype wire
